// ----- rtl/pat_pkg.sv -----
// Shared package for the periodic alarm table.
// Holds op codes, table defaults and the shared adder request type.
// No dependencies.
package pat_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_FIRE  = 16;
  localparam int FIRE_W    = $clog2(MAX_FIRE + 1);
  localparam int TIME_W    = 32;

  localparam logic [TIME_W-1:0] TOL_RESET = 32'd15;

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_UNREGISTER = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

endpackage

// ----- rtl/periodic_alarm_table.sv -----
// Periodic alarm table: top level with slot table, scan sequencer and output stage.
// Depends on pat_pkg and pat_addsub.
//
//  channel | signals                                         | direction | flow control
//  --------+-------------------------------------------------+-----------+-------------
//  in      | in_op, in_slot, in_alarm_time, in_period,       | to block  | in_valid /
//          | in_now_time                                     |           | in_stall
//  out     | out_fired_slot, out_last_fired                  | from block| out_valid /
//          |                                                 |           | out_stall
//  cfg     | cfg_late_tolerance                              | to block  | cfg_valid /
//          |                                                 |           | cfg_ready
//
// Register and unregister items complete on transfer; the block stays ready for the next item.
// A tick walks the slots with one shared adder and a one-port table memory:
//   an invalid slot is skipped in S_RD, a valid slot is read in S_RD and checked
//   in S_CMP, and a due slot also gets its write-back in S_UPD; the scan closes
//   with the end check in S_RD and the flush of the last report in S_FLUSH.
// Reset (rst_n low, synchronous) clears all valid bits, the pending and output
// valid flags and sets the tolerance to 15; the table payload is not cleared.
// A stall on out only holds the scan while a finished report cannot move on.
module periodic_alarm_table #(
  parameter int SLOTS = pat_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [3:0]                  in_slot,
  input  logic [pat_pkg::TIME_W-1:0]  in_alarm_time,
  input  logic [pat_pkg::TIME_W-1:0]  in_period,
  input  logic [pat_pkg::TIME_W-1:0]  in_now_time,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_fired_slot,
  output logic                        out_last_fired,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pat_pkg::TIME_W-1:0]  cfg_late_tolerance
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TW     = pat_pkg::TIME_W;
  localparam int FIRE_W = pat_pkg::FIRE_W;

  // Scan sequencer, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,  // check end / valid bit, issue table read
    S_CMP   = 5'b00100,  // now - due against tolerance
    S_UPD   = 5'b01000,  // due + period write-back, queue report
    S_FLUSH = 5'b10000   // hand over the last report of the tick
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       scan_idx_r;
  logic [FIRE_W-1:0]      fire_cnt_r;
  logic [TW-1:0]          now_r;
  logic [TW-1:0]          tol_r;
  logic [SLOTS-1:0]       slot_valid_r;

  // table entry: {period, due time}
  logic [2*TW-1:0]        table_mem [SLOTS];
  logic [2*TW-1:0]        rd_data_r;

  // one report held back until we know whether it is the last of the tick
  logic                   pend_valid_r;
  logic [3:0]             pend_slot_r;

  logic                   out_valid_r;
  logic [3:0]             out_slot_r;
  logic                   out_last_r;

  logic                   in_xfer;
  logic [6:0]             slot_ext;
  logic                   slot_ok;
  logic [IDX_W-1:0]       slot_idx;
  logic [IDX_W-1:0]       scan_addr;
  logic [6:0]             scan_ext;
  logic                   scan_end;
  logic                   cur_valid;
  logic                   is_due;
  logic                   out_free;
  logic                   upd_go;
  logic                   flush_go;
  logic                   idx_step;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [2*TW-1:0]        wr_data;
  logic [TW-1:0]          due_q;
  logic [TW-1:0]          per_q;
  pat_pkg::alu_req_t      alu_req;
  logic [TW-1:0]          alu_res;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign slot_ext  = 7'(in_slot);
  assign slot_ok   = slot_ext < 7'(SLOTS);
  assign slot_idx  = slot_ext[IDX_W-1:0];

  assign scan_addr = scan_idx_r[IDX_W-1:0];
  assign scan_ext  = 7'(scan_idx_r);
  assign scan_end  = (scan_idx_r == CNT_W'(SLOTS)) ||
                     (fire_cnt_r == FIRE_W'(pat_pkg::MAX_FIRE));
  assign cur_valid = slot_valid_r[scan_addr];

  assign due_q = rd_data_r[TW-1:0];
  assign per_q = rd_data_r[2*TW-1:TW];

  // shared adder: wrapping difference in S_CMP, due-time advance otherwise
  always_comb begin
    alu_req.sub = (state_r == S_CMP);
    alu_req.a   = (state_r == S_CMP) ? now_r : due_q;
    alu_req.b   = (state_r == S_CMP) ? due_q : per_q;
  end

  pat_addsub u_addsub (
    .req (alu_req),
    .res (alu_res)
  );

  assign is_due   = (alu_res <= tol_r);
  assign out_free = !out_valid_r || !out_stall;
  // a new report displaces the pending one into the output register
  assign upd_go   = (state_r == S_UPD)   && (!pend_valid_r || out_free);
  assign flush_go = (state_r == S_FLUSH) && (!pend_valid_r || out_free);

  assign idx_step = ((state_r == S_RD) && !scan_end && !cur_valid) ||
                    ((state_r == S_CMP) && !is_due) ||
                    upd_go;

  // single table write port: register item or due-time write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan_addr;
    wr_data = {per_q, alu_res};
    if (in_xfer && (in_op == pat_pkg::OP_REGISTER) && slot_ok) begin
      wr_en   = 1'b1;
      wr_addr = slot_idx;
      wr_data = {in_period, in_alarm_time};
    end else if (upd_go) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_op == pat_pkg::OP_TICK)) state_nxt = S_RD;
      end
      S_RD: begin
        if (scan_end)       state_nxt = S_FLUSH;
        else if (cur_valid) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = is_due ? S_UPD : S_RD;
      end
      S_UPD: begin
        if (upd_go) state_nxt = S_RD;
      end
      S_FLUSH: begin
        if (flush_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_idx_r   <= '0;
      fire_cnt_r   <= '0;
      tol_r        <= pat_pkg::TOL_RESET;
      slot_valid_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) tol_r <= cfg_late_tolerance;

      if (in_xfer && slot_ok) begin
        if (in_op == pat_pkg::OP_REGISTER)   slot_valid_r[slot_idx] <= 1'b1;
        if (in_op == pat_pkg::OP_UNREGISTER) slot_valid_r[slot_idx] <= 1'b0;
      end

      if (in_xfer && (in_op == pat_pkg::OP_TICK)) begin
        scan_idx_r <= '0;
        fire_cnt_r <= '0;
      end else if (idx_step) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end

      if (upd_go) begin
        fire_cnt_r   <= fire_cnt_r + FIRE_W'(1);
        pend_valid_r <= 1'b1;
      end else if (flush_go) begin
        pend_valid_r <= 1'b0;
      end

      if ((upd_go || flush_go) && pend_valid_r) out_valid_r <= 1'b1;
      else if (!out_stall)                      out_valid_r <= 1'b0;
    end
  end

  // payload registers and table
  always_ff @(posedge clk) begin
    if (in_xfer) now_r <= in_now_time;
    if (wr_en) table_mem[wr_addr] <= wr_data;
    if ((state_r == S_RD) && !scan_end && cur_valid) rd_data_r <= table_mem[scan_addr];
    if (upd_go) pend_slot_r <= scan_ext[3:0];
    if ((upd_go || flush_go) && pend_valid_r) begin
      out_slot_r <= pend_slot_r;
      out_last_r <= flush_go;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired_slot = out_slot_r;
  assign out_last_fired = out_last_r;

endmodule

// ----- rtl/pat_addsub.sv -----
// Shared 32-bit add/subtract unit of the alarm table sequencer.
// Depends on pat_pkg (alu_req_t, TIME_W).
module pat_addsub (
  input  pat_pkg::alu_req_t            req,
  output logic [pat_pkg::TIME_W-1:0]   res
);

  logic [pat_pkg::TIME_W-1:0] b_op;

  // subtract as a + ~b + 1
  assign b_op = req.sub ? ~req.b : req.b;
  assign res  = req.a + b_op + pat_pkg::TIME_W'(req.sub);

endmodule

// ----- rtl/pat_checker.sv -----
// Port-level checker for the periodic alarm table, bound to the top level.
// Depends on pat_pkg (op codes) and periodic_alarm_table.
module pat_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  in_op,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [3:0]                  out_fired_slot,
  input logic                        out_last_fired
);

  // a tick always occupies the block for at least the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == pat_pkg::OP_TICK)) |=> in_stall)
    else $error("tick transfer not followed by busy");

  // register/unregister items never produce a report
  a_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op != pat_pkg::OP_TICK) && !out_valid) |=> !out_valid)
    else $error("report after non-tick item");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_fired_slot) && $stable(out_last_fired)))
    else $error("stalled report changed");

endmodule

bind periodic_alarm_table pat_checker u_pat_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_op          (in_op),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_fired_slot (out_fired_slot),
  .out_last_fired (out_last_fired)
);
